@@ sv/mlfs_pkg.sv @@
// ----------------------------------------------------------------------------
// Multilevel feedback scheduler package
// Shared widths, result codes, controller states and the command and status
// structures between the controller and the datapath.
// ----------------------------------------------------------------------------
package mlfs_pkg;

    localparam int TIME_W  = 17;
    localparam int TICK_W  = 16;
    localparam int PID_W   = 4;
    localparam int LVL_W   = 4;
    localparam int CODE_W  = 3;

    localparam logic [TIME_W-1:0] TIME_MAX = 17'h1FFFF;
    localparam logic [TICK_W-1:0] END_RESET = 16'hFFFF;

    localparam logic [CODE_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [CODE_W-1:0] ST_REJECTED = 3'd1;
    localparam logic [CODE_W-1:0] ST_RAN      = 3'd2;
    localparam logic [CODE_W-1:0] ST_IDLE     = 3'd3;
    localparam logic [CODE_W-1:0] ST_PAST_END = 3'd4;

    localparam logic ACT_ARRIVE   = 1'b0;
    localparam logic ACT_DISPATCH = 1'b1;

    typedef enum logic [1:0] {
        S_WAIT,
        S_FETCH,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic take;
        logic fetch;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic run;
        logic out_free;
    } t_dp_stat;

endpackage

@@ sv/mlfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// Multilevel feedback scheduler controller
// Sequences one item at a time: accept, then for a run the service store read
// and the time and queue update.
// ----------------------------------------------------------------------------
module mlfs_ctrl
    import mlfs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_cmd     o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        unique case (r_state)
            S_WAIT: begin
                o_in_stall = !i_stat.out_free;
                o_cmd.take = i_in_valid && i_stat.out_free;
                if (o_cmd.take && i_stat.run) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_WAIT;
                end
            end
            default: begin
                n_state = S_WAIT;
            end
        endcase
    end

    a_fetch_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FETCH |=> r_state == S_EXEC)
        else $error("fetch not followed by exec");

    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> r_state == S_WAIT)
        else $error("exec did not return to wait");

    a_exec_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && !i_stat.out_free) |=> r_state == S_EXEC)
        else $error("exec left while result slot busy");

endmodule

@@ sv/mlfs_dp.sv @@
// ----------------------------------------------------------------------------
// Multilevel feedback scheduler datapath
// Level queues, remaining service store, active set, time and result register.
// ----------------------------------------------------------------------------
module mlfs_dp
    import mlfs_pkg::*;
#(
    parameter int NUM_LEVELS = 10,
    parameter int MAX_PROCS  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_dp_stat          o_stat,
    input  logic              i_cfg_we,
    input  logic [TICK_W-1:0] i_cfg_data,
    input  logic              i_action,
    input  logic [PID_W-1:0]  i_process_id,
    input  logic [TICK_W-1:0] i_svc_ticks,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CODE_W-1:0] o_status,
    output logic [PID_W-1:0]  o_run_process,
    output logic [LVL_W-1:0]  o_run_level,
    output logic [TIME_W-1:0] o_run_start,
    output logic [TIME_W-1:0] o_run_end,
    output logic              o_finished
);

    localparam int LW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int SW    = $clog2(MAX_PROCS);
    localparam int CW    = $clog2(MAX_PROCS + 1);
    localparam int DEPTH = NUM_LEVELS * MAX_PROCS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [SW-1:0]     mem_fifo [DEPTH];
    logic [TICK_W-1:0] mem_rem [MAX_PROCS];

    logic [SW-1:0]     r_head [NUM_LEVELS];
    logic [SW-1:0]     r_tail [NUM_LEVELS];
    logic [CW-1:0]     r_count [NUM_LEVELS];
    logic [MAX_PROCS-1:0] r_active;
    logic [TIME_W-1:0] r_now;
    logic [TICK_W-1:0] r_end;
    logic [SW-1:0]     r_fifo_q;
    logic [TICK_W-1:0] r_rem_q;
    logic [SW-1:0]     r_id;
    logic [LW-1:0]     r_lvl;
    logic [TIME_W-1:0] r_start;

    logic              r_out_valid;
    logic [CODE_W-1:0] r_status;
    logic [PID_W-1:0]  r_proc;
    logic [LVL_W-1:0]  r_level;
    logic [TIME_W-1:0] r_run_start;
    logic [TIME_W-1:0] r_run_end;
    logic              r_fin;

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
        return (s == SW'(MAX_PROCS - 1)) ? '0 : s + 1'b1;
    endfunction

    logic [NUM_LEVELS-1:0] w_busy;
    logic [LW-1:0]         w_lvl;
    logic                  w_any;
    logic [8:0]            w_pid_ext;
    logic [SW-1:0]         w_pid;
    logic                  w_reject;
    logic                  w_past_end;
    logic                  w_arrive_ok;
    logic                  w_take_run;

    always_comb begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
            w_busy[i] = (r_count[i] != '0);
        end
        w_lvl = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (w_busy[i]) begin
                w_lvl = LW'(i);
            end
        end
        w_any = |w_busy;
    end

    assign w_pid_ext   = {{(9 - PID_W){1'b0}}, i_process_id};
    assign w_pid       = w_pid_ext[SW-1:0];
    assign w_reject    = (w_pid_ext >= 9'(MAX_PROCS)) || (i_svc_ticks == '0)
                         || r_active[w_pid];
    assign w_past_end  = r_now > {1'b0, r_end};
    assign w_arrive_ok = i_cmd.take && (i_action == ACT_ARRIVE) && !w_reject;
    assign w_take_run  = i_cmd.take && i_cmd.take && o_stat.run;

    assign o_stat.run      = (i_action != ACT_ARRIVE) && !w_past_end && w_any;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    // Run arithmetic on the fetched process.
    logic [TIME_W-1:0] w_quantum;
    logic [TIME_W-1:0] w_rem_ext;
    logic [TIME_W-1:0] w_slice;
    logic [TIME_W:0]   w_sum;
    logic [TIME_W-1:0] w_now_run;
    logic [TICK_W-1:0] w_rem_new;
    logic              w_done;
    logic [LW-1:0]     w_push_lvl;
    logic              w_push;
    logic [8:0]        w_id_ext;
    logic [8:0]        w_lvl_ext;

    always_comb begin
        w_quantum  = TIME_W'(1) << r_lvl;
        w_rem_ext  = {1'b0, r_rem_q};
        w_slice    = (w_quantum < w_rem_ext) ? w_quantum : w_rem_ext;
        w_sum      = {1'b0, r_now} + {1'b0, w_slice};
        w_now_run  = (w_sum > {1'b0, TIME_MAX}) ? TIME_MAX : w_sum[TIME_W-1:0];
        w_rem_new  = r_rem_q - w_slice[TICK_W-1:0];
        w_done     = (w_rem_new == '0);
        w_push_lvl = (r_lvl == LW'(NUM_LEVELS - 1)) ? r_lvl : r_lvl + 1'b1;
        w_push     = i_cmd.exec && !w_done && (r_count[w_push_lvl] < CW'(MAX_PROCS));
        w_id_ext   = 9'(r_id);
        w_lvl_ext  = 9'(r_lvl);
    end

    // Single write port for each store.
    logic              w_fifo_we;
    logic [AW-1:0]     w_fifo_wa;
    logic [SW-1:0]     w_fifo_wd;
    logic              w_rem_we;
    logic [SW-1:0]     w_rem_wa;
    logic [TICK_W-1:0] w_rem_wd;

    always_comb begin
        w_fifo_we = 1'b0;
        w_fifo_wa = AW'(r_tail[0]);
        w_fifo_wd = w_pid;
        w_rem_we  = 1'b0;
        w_rem_wa  = w_pid;
        w_rem_wd  = i_svc_ticks;
        if (w_arrive_ok) begin
            w_fifo_we = r_count[0] < CW'(MAX_PROCS);
            w_rem_we  = 1'b1;
        end else if (i_cmd.exec) begin
            w_fifo_we = w_push;
            w_fifo_wa = AW'(w_push_lvl * MAX_PROCS) + AW'(r_tail[w_push_lvl]);
            w_fifo_wd = r_id;
            w_rem_we  = 1'b1;
            w_rem_wa  = r_id;
            w_rem_wd  = w_rem_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fifo_we) begin
            mem_fifo[w_fifo_wa] <= w_fifo_wd;
        end
        r_fifo_q <= mem_fifo[AW'(w_lvl * MAX_PROCS) + AW'(r_head[w_lvl])];
    end

    always_ff @(posedge i_clk) begin
        if (w_rem_we) begin
            mem_rem[w_rem_wa] <= w_rem_wd;
        end
        if (i_cmd.fetch) begin
            r_rem_q <= mem_rem[r_fifo_q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
            r_active <= '0;
            r_now    <= '0;
            r_end    <= END_RESET;
        end else begin
            if (i_cfg_we) begin
                r_end <= i_cfg_data;
            end
            if (w_arrive_ok) begin
                r_active[w_pid] <= 1'b1;
                if (r_count[0] < CW'(MAX_PROCS)) begin
                    r_tail[0]  <= next_slot(r_tail[0]);
                    r_count[0] <= r_count[0] + 1'b1;
                end
            end
            if (w_take_run) begin
                r_head[w_lvl]  <= next_slot(r_head[w_lvl]);
                r_count[w_lvl] <= r_count[w_lvl] - 1'b1;
            end
            if (i_cmd.take && (i_action != ACT_ARRIVE) && !w_past_end && !w_any
                && (r_now < TIME_MAX)) begin
                r_now <= r_now + 1'b1;
            end
            if (i_cmd.exec) begin
                r_now <= w_now_run;
                if (w_done) begin
                    r_active[r_id] <= 1'b0;
                end
                if (w_push) begin
                    r_tail[w_push_lvl]  <= next_slot(r_tail[w_push_lvl]);
                    r_count[w_push_lvl] <= r_count[w_push_lvl] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_run) begin
            r_lvl   <= w_lvl;
            r_start <= r_now;
        end
        if (i_cmd.fetch) begin
            r_id <= r_fifo_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec || (i_cmd.take && !o_stat.run)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status    <= ST_RAN;
            r_proc      <= w_id_ext[PID_W-1:0];
            r_level     <= w_lvl_ext[LVL_W-1:0];
            r_run_start <= r_start;
            r_run_end   <= w_now_run;
            r_fin       <= w_done;
        end else if (i_cmd.take && !o_stat.run) begin
            r_proc      <= '0;
            r_level     <= '0;
            r_run_start <= r_now;
            r_run_end   <= r_now;
            r_fin       <= 1'b0;
            if (i_action == ACT_ARRIVE) begin
                r_status <= w_reject ? ST_REJECTED : ST_ACCEPTED;
            end else if (w_past_end) begin
                r_status <= ST_PAST_END;
            end else begin
                r_status  <= ST_IDLE;
                r_run_end <= (r_now < TIME_MAX) ? r_now + 1'b1 : r_now;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_run_process = r_proc;
    assign o_run_level   = r_level;
    assign o_run_start   = r_run_start;
    assign o_run_end     = r_run_end;
    assign o_finished    = r_fin;

endmodule

@@ sv/multilevel_feedback_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// Multilevel feedback scheduler core
// Level queues with quantum two to the power of the level, driven by arrive
// and dispatch items, one result item for each.
// ----------------------------------------------------------------------------
// An arrive item, and a dispatch that finds nothing queued or the time past
// the end, has its result registered when it is taken. A dispatch that runs
// a process goes through three steps: the queue store read, the service
// store read, then the time and queue update, as both stores have registered
// reads. One item is in work at a time, and the next item is taken no earlier
// than the cycle in which the previous result leaves the output register.
// Nothing needs clearing after reset.
module multilevel_feedback_scheduler_core
    import mlfs_pkg::*;
#(
    parameter int NUM_LEVELS = 10,
    parameter int MAX_PROCS  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TICK_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_action,
    input  logic [PID_W-1:0]  i_process_id,
    input  logic [TICK_W-1:0] i_svc_ticks,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CODE_W-1:0] o_status,
    output logic [PID_W-1:0]  o_run_process,
    output logic [LVL_W-1:0]  o_run_level,
    output logic [TIME_W-1:0] o_run_start,
    output logic [TIME_W-1:0] o_run_end,
    output logic              o_finished
);

    t_cmd     w_cmd;
    t_dp_stat w_stat;

    mlfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mlfs_dp #(
        .NUM_LEVELS (NUM_LEVELS),
        .MAX_PROCS  (MAX_PROCS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_action       (i_action),
        .i_process_id   (i_process_id),
        .i_svc_ticks    (i_svc_ticks),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_run_process  (o_run_process),
        .o_run_level    (o_run_level),
        .o_run_start    (o_run_start),
        .o_run_end      (o_run_end),
        .o_finished     (o_finished)
    );

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// Multilevel feedback scheduler core testbench
// Drives arrive and dispatch items through the valid and stall handshake with
// random gaps on both sides, predicts every result with a scheduler model of
// its own, and compares each result item field by field in order. The end
// time register is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb
    import mlfs_pkg::*;
();

    localparam int LEVELS   = 10;
    localparam int PROCS    = 16;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic [CODE_W-1:0] status;
        logic [PID_W-1:0]  proc_id;
        logic [LVL_W-1:0]  lvl;
        logic [TIME_W-1:0] t_start;
        logic [TIME_W-1:0] t_end;
        logic              fin;
    } t_sched_res;

    typedef struct packed {
        logic              act;
        logic [PID_W-1:0]  pid;
        logic [TICK_W-1:0] svc;
        logic              chk;
        logic [CODE_W-1:0] status;
    } t_row;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [TICK_W-1:0] cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              action = 1'b0;
    logic [PID_W-1:0]  process_id = '0;
    logic [TICK_W-1:0] svc_ticks = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CODE_W-1:0] status;
    logic [PID_W-1:0]  run_process;
    logic [LVL_W-1:0]  run_level;
    logic [TIME_W-1:0] run_start;
    logic [TIME_W-1:0] run_end;
    logic              finished;

    logic [PID_W-1:0]  q_store [LEVELS][$];
    logic [TICK_W-1:0] rem_ticks [PROCS];
    logic [PROCS-1:0]  active;
    logic [TIME_W-1:0] now_t;
    logic [TICK_W-1:0] end_time;

    t_sched_res        sched_expect [$];
    int                errors = 0;
    int                n_items = 0;
    int                n_results = 0;
    int                n_ran = 0;
    int                n_rej = 0;
    int                n_past = 0;
    int                quiet = 0;

    multilevel_feedback_scheduler_core uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_action       (action),
        .i_process_id   (process_id),
        .i_svc_ticks    (svc_ticks),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (status),
        .o_run_process  (run_process),
        .o_run_level    (run_level),
        .o_run_start    (run_start),
        .o_run_end      (run_end),
        .o_finished     (finished)
    );

    always #5 clk = ~clk;

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 n_results, what, got, want);
    endtask

    function automatic t_sched_res schedule_step(input logic act, input logic [PID_W-1:0] pid,
                                                 input logic [TICK_W-1:0] svc);
        t_sched_res r;
        int lv;
        int run_t;
        logic [PID_W-1:0] id;
        r = '0;
        r.t_start = now_t;
        if (act == ACT_ARRIVE) begin
            if (svc == 0 || active[pid]) begin
                r.status = ST_REJECTED;
            end else begin
                rem_ticks[pid] = svc;
                active[pid] = 1'b1;
                q_store[0] = {q_store[0], pid};
                r.status = ST_ACCEPTED;
            end
        end else if (now_t > {1'b0, end_time}) begin
            r.status = ST_PAST_END;
        end else begin
            lv = 0;
            while (lv < LEVELS && q_store[lv].size() == 0) lv++;
            if (lv >= LEVELS) begin
                if (now_t < TIME_MAX) now_t = now_t + 1'b1;
                r.status = ST_IDLE;
            end else begin
                id = q_store[lv].pop_front();
                run_t = (rem_ticks[id] < (1 << lv)) ? rem_ticks[id] : (1 << lv);
                now_t = (now_t + run_t > TIME_MAX) ? TIME_MAX : TIME_W'(now_t + run_t);
                rem_ticks[id] = rem_ticks[id] - TICK_W'(run_t);
                if (rem_ticks[id] == 0) begin
                    r.fin = 1'b1;
                    active[id] = 1'b0;
                end else if (lv + 1 < LEVELS) begin
                    q_store[lv + 1] = {q_store[lv + 1], id};
                end else begin
                    q_store[lv] = {q_store[lv], id};
                end
                r.proc_id = id;
                r.lvl = LVL_W'(lv);
                r.status = ST_RAN;
            end
        end
        r.t_end = now_t;
        return r;
    endfunction

    task automatic send_item(input logic act, input logic [PID_W-1:0] pid,
                             input logic [TICK_W-1:0] svc, input bit chk,
                             input logic [CODE_W-1:0] want);
        t_sched_res r;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        process_id <= pid;
        svc_ticks <= svc;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        r = schedule_step(act, pid, svc);
        if (chk && r.status != want) report("predicted status", r.status, want);
        sched_expect.push_back(r);
        if (r.status == ST_RAN) n_ran++;
        if (r.status == ST_REJECTED) n_rej++;
        if (r.status == ST_PAST_END) n_past++;
        n_items++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sched_expect.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_end(input logic [TICK_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        end_time = v;
    endtask

    always @(posedge clk) begin
        t_sched_res e;
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
            else quiet <= quiet + 1;
            if (quiet >= WD_LIMIT) begin
                $display("watchdog: no item accepted for %0d cycles", WD_LIMIT);
                $display("** multilevel_feedback_scheduler_core: FAILED **");
                $finish;
            end
        end
        if (out_valid && !out_stall) begin
            n_results++;
            if (sched_expect.size() == 0) begin
                report("unexpected result status", status, 0);
            end else begin
                e = sched_expect.pop_front();
                if (status != e.status) report("status", status, e.status);
                if (run_process != e.proc_id) report("run_process", run_process, e.proc_id);
                if (run_level != e.lvl) report("run_level", run_level, e.lvl);
                if (run_start != e.t_start) report("run_start", run_start, e.t_start);
                if (run_end != e.t_end) report("run_end", run_end, e.t_end);
                if (finished != e.fin) report("finished", finished, e.fin);
            end
        end
    end

    initial begin
        int wait_n;
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) begin
                wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
                if (wait_n != 0) begin
                    out_stall <= 1'b1;
                    repeat (wait_n) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    t_row dir_rows [] = '{
        '{ACT_DISPATCH, 4'd0,  16'd0,     1'b1, ST_IDLE},
        '{ACT_ARRIVE,   4'd0,  16'd0,     1'b1, ST_REJECTED},
        '{ACT_ARRIVE,   4'd0,  16'd1,     1'b1, ST_ACCEPTED},
        '{ACT_ARRIVE,   4'd0,  16'd5,     1'b1, ST_REJECTED},
        '{ACT_ARRIVE,   4'd15, 16'hFFFF,  1'b1, ST_ACCEPTED},
        '{ACT_ARRIVE,   4'd7,  16'd6,     1'b1, ST_ACCEPTED},
        '{ACT_DISPATCH, 4'd0,  16'd0,     1'b1, ST_RAN},
        '{ACT_DISPATCH, 4'd15, 16'hFFFF,  1'b1, ST_RAN},
        '{ACT_DISPATCH, 4'd0,  16'd0,     1'b1, ST_RAN},
        '{ACT_ARRIVE,   4'd0,  16'd3,     1'b1, ST_ACCEPTED},
        '{ACT_DISPATCH, 4'd0,  16'd0,     1'b0, ST_RAN},
        '{ACT_DISPATCH, 4'd0,  16'd0,     1'b0, ST_RAN},
        '{ACT_DISPATCH, 4'd0,  16'd0,     1'b0, ST_RAN},
        '{ACT_DISPATCH, 4'd0,  16'd0,     1'b0, ST_RAN},
        '{ACT_DISPATCH, 4'd0,  16'd0,     1'b0, ST_RAN},
        '{ACT_ARRIVE,   4'd10, 16'h5555,  1'b0, ST_ACCEPTED},
        '{ACT_ARRIVE,   4'd5,  16'hAAAA,  1'b0, ST_ACCEPTED}
    };

    initial begin
        int sel;
        logic [TICK_W-1:0] sv;
        for (int i = 0; i < PROCS; i++) rem_ticks[i] = '0;
        active = '0;
        now_t = '0;
        end_time = END_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].act, dir_rows[i].pid, dir_rows[i].svc,
                      dir_rows[i].chk, dir_rows[i].status);
        drain();

        // End time zero: the time is already past it, so each dispatch reports past end.
        write_end(16'd0);
        for (int i = 0; i < 4; i++) send_item(ACT_DISPATCH, 4'd0, 16'd0, 1'b1, ST_PAST_END);
        drain();
        write_end(16'hFFFF);

        for (int ph = 0; ph < 6; ph++) begin
            for (int k = 0; k < 250; k++) begin
                sel = $urandom_range(0, 99);
                sv = ($urandom_range(0, 9) == 0) ? TICK_W'($urandom)
                                                 : TICK_W'($urandom_range(1, 40));
                if (sel < 8) sv = (sel < 2) ? 16'd0 : sv;
                if (sel < 40) send_item(ACT_ARRIVE, PID_W'($urandom), sv, 1'b0, ST_ACCEPTED);
                else send_item(ACT_DISPATCH, PID_W'($urandom), TICK_W'($urandom), 1'b0,
                               ST_ACCEPTED);
            end
            drain();
            case (ph)
                0: write_end(16'hFFFF);
                1: write_end(now_t[TICK_W-1:0] + 16'd200);
                2: write_end(16'hFFFF);
                3: write_end(16'd0);
                default: write_end(TICK_W'($urandom));
            endcase
        end
        drain();

        $display("%0d items, %0d runs, %0d rejected arrivals, %0d past-end dispatches",
                 n_items, n_ran, n_rej, n_past);
        $display("final kept time %0d, %0d result items checked", now_t, n_results);
        if (errors == 0) begin
            $display("** multilevel_feedback_scheduler_core: PASSED **");
        end else begin
            $display("** multilevel_feedback_scheduler_core: FAILED **");
        end
        $finish;
    end
endmodule
